### rtl/cbpm_pkg.sv
`default_nettype none
package cbpm_pkg;
  localparam int NumFramesDefault = 32;
  localparam int PinBitsDefault = 16;
  localparam int MaxResults = 32;

  typedef enum logic [2:0] {
    OP_READ    = 3'd0,
    OP_ALLOC   = 3'd1,
    OP_UNPIN   = 3'd2,
    OP_DISPOSE = 3'd3,
    OP_FLUSH   = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EXCEEDED = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_NOTPIN   = 3'd3,
    ST_PINNED   = 3'd4,
    ST_INVALID  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    CMD_NONE   = 3'd0,
    CMD_LATCH  = 3'd1,
    CMD_HIT    = 3'd2,
    CMD_UNPIN  = 3'd3,
    CMD_CLEAR  = 3'd4,
    CMD_CLAIM  = 3'd5,
    CMD_REFCLR = 3'd6
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
  } dp_ctl_t;

  typedef struct packed {
    logic       vld;
    logic       tag_eq;
    logic       file_eq;
    logic       refb;
    logic       pinned;
    logic       dirty;
  } dp_stat_t;
endpackage
`default_nettype wire

### rtl/cbpm_datapath.sv
`default_nettype none
module cbpm_datapath import cbpm_pkg::*; #(
  parameter int NUM_FRAMES = NumFramesDefault,
  parameter int PIN_BITS = PinBitsDefault,
  localparam int IW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [IW-1:0] idx,
  input  wire logic [7:0]    file_id,
  input  wire logic [31:0]   page_num,
  input  wire logic          mark_dirty,
  input  wire dp_ctl_t       ctl,
  output dp_stat_t           stat,
  output logic [7:0]         cur_file,
  output logic [31:0]        cur_page
);
  logic [NUM_FRAMES-1:0] valid, refb, dirty;
  logic [PIN_BITS-1:0]   pin [NUM_FRAMES];
  logic [7:0]            ffile [NUM_FRAMES];
  logic [31:0]           fpage [NUM_FRAMES];

  assign cur_file = ffile[idx];
  assign cur_page = fpage[idx];
  assign stat.vld = valid[idx];
  assign stat.file_eq = valid[idx] && ffile[idx] == file_id;
  assign stat.tag_eq = stat.file_eq && fpage[idx] == page_num;
  assign stat.refb = refb[idx];
  assign stat.pinned = pin[idx] != '0;
  assign stat.dirty = dirty[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      refb <= '0;
      dirty <= '0;
      for (int i = 0; i < NUM_FRAMES; i++) pin[i] <= '0;
    end else begin
      case (ctl.cmd)
        CMD_HIT: begin
          refb[idx] <= 1'b1;
          if (pin[idx] != '1) pin[idx] <= pin[idx] + 1'b1;
        end
        CMD_UNPIN: begin
          if (mark_dirty) dirty[idx] <= 1'b1;
          if (pin[idx] != '0) pin[idx] <= pin[idx] - 1'b1;
        end
        CMD_CLEAR: begin
          valid[idx] <= 1'b0;
          refb[idx] <= 1'b0;
          dirty[idx] <= 1'b0;
          pin[idx] <= '0;
        end
        CMD_REFCLR: refb[idx] <= 1'b0;
        CMD_CLAIM: begin
          valid[idx] <= 1'b1;
          refb[idx] <= 1'b1;
          dirty[idx] <= 1'b0;
          pin[idx] <= PIN_BITS'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cmd == CMD_CLAIM) begin
      ffile[idx] <= file_id;
      fpage[idx] <= page_num;
    end
  end
endmodule
`default_nettype wire

### rtl/cbpm_ctrl.sv
`default_nettype none
module cbpm_ctrl import cbpm_pkg::*; #(
  parameter int NUM_FRAMES = NumFramesDefault,
  localparam int IW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1,
  localparam int SW = $clog2(2 * NUM_FRAMES + 1),
  localparam int RW = $clog2(MaxResults + 1)
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  operation,
  output logic [2:0]       op_q,
  output logic [IW-1:0]    idx,
  output dp_ctl_t          ctl,
  input  wire dp_stat_t    stat,
  input  wire logic [7:0]  cur_file,
  input  wire logic [31:0] cur_page,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       status,
  output logic [4:0]       frame_index,
  output logic             hit,
  output logic             writeback,
  output logic [7:0]       writeback_file,
  output logic [31:0]      writeback_page,
  output logic             last
);
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LOOK  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_FLUSH = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t state;
  logic [IW-1:0] hand, scan, hand_next;
  logic [SW-1:0] steps;
  logic [RW-1:0] nres;
  logic flush_done;
  logic held;

  assign in_ready = (state == S_IDLE) && !out_valid;
  assign idx = (state == S_SCAN) ? hand_next : scan;
  assign hand_next = (hand == IW'(NUM_FRAMES - 1)) ? '0 : hand + 1'b1;
  wire scan_end = scan == IW'(NUM_FRAMES - 1);

  always_comb begin
    ctl.cmd = CMD_NONE;
    case (state)
      S_LOOK:
        if (stat.tag_eq)
          case (op_q)
            OP_READ: ctl.cmd = CMD_HIT;
            OP_UNPIN: ctl.cmd = CMD_UNPIN;
            OP_DISPOSE: ctl.cmd = CMD_CLEAR;
            default: ;
          endcase
      S_SCAN:
        if (!stat.vld) ctl.cmd = CMD_CLAIM;
        else if (stat.refb) ctl.cmd = CMD_REFCLR;
        else if (!stat.pinned) ctl.cmd = CMD_CLAIM;
      S_FLUSH:
        if (!out_valid && !flush_done && stat.file_eq && !stat.pinned &&
            (!stat.dirty || (!held && nres != RW'(MaxResults))))
          ctl.cmd = CMD_CLEAR;
      default: ;
    endcase
    if (state == S_FLUSH && out_valid) ctl.cmd = CMD_NONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      hand <= IW'(NUM_FRAMES - 1);
      flush_done <= 1'b0;
      held <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE:
          if (in_valid && in_ready) begin
            op_q <= operation;
            scan <= '0;
            nres <= '0;
            steps <= '0;
            held <= 1'b0;
            if (operation == OP_FLUSH) state <= S_FLUSH;
            else if (operation == OP_READ || operation == OP_ALLOC ||
                     operation == OP_UNPIN || operation == OP_DISPOSE)
              state <= S_LOOK;
          end
        S_LOOK: begin
          status <= ST_OK;
          frame_index <= 5'(scan);
          hit <= 1'b0;
          writeback <= 1'b0;
          writeback_file <= '0;
          writeback_page <= '0;
          last <= 1'b1;
          if (stat.tag_eq) begin
            state <= S_OUT;
            case (op_q)
              OP_READ: hit <= 1'b1;
              OP_ALLOC: status <= ST_INVALID;
              OP_UNPIN: if (!stat.pinned) status <= ST_NOTPIN;
              default: ;
            endcase
          end else if (scan_end) begin
            frame_index <= '0;
            case (op_q)
              OP_READ, OP_ALLOC: state <= S_SCAN;
              OP_UNPIN: begin
                status <= ST_NOTFOUND;
                state <= S_OUT;
              end
              default: begin
                status <= ST_INVALID;
                state <= S_OUT;
              end
            endcase
          end else scan <= scan + 1'b1;
        end
        S_SCAN: begin
          steps <= steps + 1'b1;
          hand <= hand_next;
          if (ctl.cmd == CMD_CLAIM) begin
            frame_index <= 5'(hand_next);
            if (stat.vld && stat.dirty) begin
              writeback <= 1'b1;
              writeback_file <= cur_file;
              writeback_page <= cur_page;
            end
            state <= S_OUT;
          end else if (steps == SW'(2 * NUM_FRAMES - 1)) begin
            status <= ST_EXCEEDED;
            state <= S_OUT;
          end
        end
        S_FLUSH:
          if (!out_valid) begin
            if (flush_done) begin
              flush_done <= 1'b0;
              if (held) begin
                last <= 1'b1;
                out_valid <= 1'b1;
                held <= 1'b0;
              end else if (nres == '0) begin
                status <= ST_OK;
                frame_index <= '0;
                hit <= 1'b0;
                writeback <= 1'b0;
                writeback_file <= '0;
                writeback_page <= '0;
                last <= 1'b1;
                out_valid <= 1'b1;
              end
              state <= S_IDLE;
            end else if (stat.file_eq && stat.pinned) begin
              if (nres == RW'(MaxResults)) flush_done <= 1'b1;
              else if (held) begin
                out_valid <= 1'b1;
                held <= 1'b0;
              end else begin
                status <= ST_PINNED;
                frame_index <= 5'(scan);
                hit <= 1'b0;
                writeback <= 1'b0;
                writeback_file <= '0;
                writeback_page <= '0;
                last <= 1'b1;
                out_valid <= 1'b1;
                state <= S_IDLE;
              end
            end else if (stat.file_eq && stat.dirty) begin
              if (nres == RW'(MaxResults)) flush_done <= 1'b1;
              else if (held) begin
                out_valid <= 1'b1;
                held <= 1'b0;
              end else begin
                status <= ST_OK;
                frame_index <= 5'(scan);
                hit <= 1'b0;
                writeback <= 1'b1;
                writeback_file <= cur_file;
                writeback_page <= cur_page;
                nres <= nres + 1'b1;
                last <= 1'b0;
                held <= 1'b1;
                if (scan_end) flush_done <= 1'b1;
                else scan <= scan + 1'b1;
              end
            end else if (scan_end) flush_done <= 1'b1;
            else scan <= scan + 1'b1;
          end
        S_OUT: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### rtl/clock_buffer_pool_manager_top.sv
// Clock-replacement frame table of a page buffer pool.
// Request channel: in_valid/in_ready with operation, file_id, page_num,
// mark_dirty. Result channel: out_valid/out_ready with status, frame_index,
// hit, writeback, writeback_file, writeback_page, last.
// One request is processed at a time; for a defined operation, in_ready is
// low from acceptance until the last result of that request has been accepted.
// Read, alloc, unpin and dispose walk the frame tags one frame a cycle and
// stop at the match. A miss on read or alloc then steps the clock hand one
// frame a cycle, up to 2*NUM_FRAMES steps. Each of these requests gives a
// single result.
// Flush walks the frames one a cycle while no result is pending and holds
// each writeback until the next one, a pinned frame or the end of the walk
// is found, so the final result can carry last. It ends at the first pinned
// frame of the file and gives at most MaxResults writebacks.
// When the receiver stalls, out_valid and the result hold and the walk
// waits. Undefined operation codes are accepted and dropped.
// Synchronous reset clears all frames, pins, ref and dirty bits and sets
// the hand to NUM_FRAMES-1; tags are not cleared.
`default_nettype none
module clock_buffer_pool_manager_top import cbpm_pkg::*; #(
  parameter int NUM_FRAMES = NumFramesDefault,
  parameter int PIN_BITS = PinBitsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  operation,
  input  wire logic [7:0]  file_id,
  input  wire logic [31:0] page_num,
  input  wire logic        mark_dirty,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       status,
  output logic [4:0]       frame_index,
  output logic             hit,
  output logic             writeback,
  output logic [7:0]       writeback_file,
  output logic [31:0]      writeback_page,
  output logic             last
);
  localparam int IW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  logic [IW-1:0] idx;
  logic [2:0] op_q;
  dp_ctl_t ctl;
  dp_stat_t stat;
  logic [7:0] cur_file, fid_q;
  logic [31:0] cur_page, page_q;
  logic md_q;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      fid_q <= file_id;
      page_q <= page_num;
      md_q <= mark_dirty;
    end
  end

  cbpm_ctrl #(.NUM_FRAMES(NUM_FRAMES)) u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .operation, .op_q, .idx, .ctl, .stat,
    .cur_file, .cur_page, .out_valid, .out_ready, .status, .frame_index, .hit,
    .writeback, .writeback_file, .writeback_page, .last
  );

  cbpm_datapath #(.NUM_FRAMES(NUM_FRAMES), .PIN_BITS(PIN_BITS)) u_dp (
    .clk, .rst, .idx, .file_id(fid_q), .page_num(page_q),
    .mark_dirty(md_q), .ctl, .stat, .cur_file, .cur_page
  );

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("request accepted while result pending");
  a_wb_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && writeback) |-> (status == ST_OK)) else $error("writeback with error");
  a_hit_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && hit) |-> (status == ST_OK && last)) else $error("bad hit result");
endmodule
`default_nettype wire
